// ===== design/jps_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jps_pkg: shared types, codes and microcode ROM of the joint plant
// Control word layout, register indexes, target codes and the sequencer
// program that walks one axis per pass.
// ---------------------------------------------------------------------------
package jps_pkg;

  localparam int NUM_AXES_DEF = 8;

  // Controlled quantity codes (control_target register).
  localparam logic [1:0] TGT_POSITION = 2'd0;
  localparam logic [1:0] TGT_VELOCITY = 2'd1;
  localparam logic [1:0] TGT_EFFORT   = 2'd2;

  // Register indexes on the configuration port (byte address 4*index).
  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_FOLLOW = 3'd1;
  localparam logic [2:0] REG_DAMP   = 3'd2;
  localparam logic [2:0] REG_HJ     = 3'd3;
  localparam logic [2:0] REG_STEP   = 3'd4;

  localparam logic [1:0]  TARGET_RST = TGT_EFFORT;
  localparam logic [23:0] FOLLOW_RST = 24'd167772;
  localparam logic [23:0] DAMP_RST   = 24'd1677722;
  localparam logic [23:0] HJ_RST     = 24'd16777;
  localparam logic [23:0] STEP_RST   = 24'd16777;

  // Multiplier operand select.
  typedef enum logic [2:0] {
    A_CMD, A_POS, A_VEL, A_EFF, A_ENEW, A_VNEW
  } asel_t;

  // Coefficient select.
  typedef enum logic [2:0] {
    C_TAU, C_KEEP, C_DAMP, C_HJ, C_H
  } csel_t;

  // Accumulator operation on the rounded product.
  typedef enum logic [2:0] {
    ACC_NOP, ACC_RND, ACC_ADD, ACC_SUB, ACC_VOLD, ACC_POLD
  } acc_op_t;

  // Which new-state register takes the saturated accumulator.
  typedef enum logic [1:0] {
    WR_NONE, WR_E, WR_V, WR_P
  } wr_t;

  // Sequencing of the step counter.
  typedef enum logic [2:0] {
    SQ_IDLE, SQ_NEXT, SQ_JUMP, SQ_DISPATCH, SQ_EMIT
  } seq_t;

  localparam int SAW = 5;
  typedef logic [SAW-1:0] step_t;

  // Program addresses.
  localparam step_t ST_IDLE = 5'd0;
  localparam step_t ST_WAIT = 5'd1;
  localparam step_t ST_DISP = 5'd2;
  localparam step_t ST_E0   = 5'd3;
  localparam step_t ST_E1   = 5'd4;
  localparam step_t ST_E2   = 5'd5;
  localparam step_t ST_E3   = 5'd6;
  localparam step_t ST_E4   = 5'd7;
  localparam step_t ST_E5   = 5'd8;
  localparam step_t ST_E6   = 5'd9;
  localparam step_t ST_E7   = 5'd10;
  localparam step_t ST_T0   = 5'd11;
  localparam step_t ST_T1   = 5'd12;
  localparam step_t ST_T2   = 5'd13;
  localparam step_t ST_EMIT = 5'd14;
  localparam step_t ST_V0   = 5'd15;
  localparam step_t ST_V1   = 5'd16;
  localparam step_t ST_V2   = 5'd17;
  localparam step_t ST_V3   = 5'd18;
  localparam step_t ST_P0   = 5'd19;
  localparam step_t ST_P1   = 5'd20;
  localparam step_t ST_P2   = 5'd21;
  localparam step_t ST_P3   = 5'd22;

  typedef struct packed {
    asel_t   asel;
    csel_t   csel;
    acc_op_t acc;
    wr_t     wr;
    logic    clr;
    seq_t    seq;
    step_t   jaddr;
  } uword_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    uword_t uw;
    logic   emit;
    logic   last;
  } ctl_t;

  function automatic uword_t mk(input asel_t a, input csel_t c, input acc_op_t op,
                                input wr_t w, input logic clr, input seq_t sq,
                                input step_t ja);
    uword_t u;
    u.asel  = a;
    u.csel  = c;
    u.acc   = op;
    u.wr    = w;
    u.clr   = clr;
    u.seq   = sq;
    u.jaddr = ja;
    return u;
  endfunction

  // The product of the operands selected in one step is accumulated in the
  // next one; a saturated write follows the accumulate by one more step.
  function automatic uword_t ucode_rom(input step_t addr);
    uword_t u;
    case (addr)
      ST_IDLE: u = mk(A_CMD,  C_TAU,  ACC_NOP,  WR_NONE, 1'b0, SQ_IDLE,     ST_IDLE);
      ST_WAIT: u = mk(A_CMD,  C_TAU,  ACC_NOP,  WR_NONE, 1'b1, SQ_NEXT,     ST_IDLE);
      ST_DISP: u = mk(A_CMD,  C_TAU,  ACC_NOP,  WR_NONE, 1'b0, SQ_DISPATCH, ST_IDLE);
      ST_E0:   u = mk(A_CMD,  C_TAU,  ACC_NOP,  WR_NONE, 1'b0, SQ_NEXT,     ST_IDLE);
      ST_E1:   u = mk(A_EFF,  C_KEEP, ACC_RND,  WR_NONE, 1'b0, SQ_NEXT,     ST_IDLE);
      ST_E2:   u = mk(A_VEL,  C_DAMP, ACC_ADD,  WR_NONE, 1'b0, SQ_NEXT,     ST_IDLE);
      ST_E3:   u = mk(A_CMD,  C_TAU,  ACC_SUB,  WR_NONE, 1'b0, SQ_NEXT,     ST_IDLE);
      ST_E4:   u = mk(A_CMD,  C_TAU,  ACC_NOP,  WR_E,    1'b0, SQ_NEXT,     ST_IDLE);
      ST_E5:   u = mk(A_ENEW, C_HJ,   ACC_NOP,  WR_NONE, 1'b0, SQ_NEXT,     ST_IDLE);
      ST_E6:   u = mk(A_CMD,  C_TAU,  ACC_VOLD, WR_NONE, 1'b0, SQ_NEXT,     ST_IDLE);
      ST_E7:   u = mk(A_CMD,  C_TAU,  ACC_NOP,  WR_V,    1'b0, SQ_NEXT,     ST_IDLE);
      ST_T0:   u = mk(A_VNEW, C_H,    ACC_NOP,  WR_NONE, 1'b0, SQ_NEXT,     ST_IDLE);
      ST_T1:   u = mk(A_CMD,  C_TAU,  ACC_POLD, WR_NONE, 1'b0, SQ_NEXT,     ST_IDLE);
      ST_T2:   u = mk(A_CMD,  C_TAU,  ACC_NOP,  WR_P,    1'b0, SQ_NEXT,     ST_IDLE);
      ST_EMIT: u = mk(A_CMD,  C_TAU,  ACC_NOP,  WR_NONE, 1'b0, SQ_EMIT,     ST_IDLE);
      ST_V0:   u = mk(A_CMD,  C_TAU,  ACC_NOP,  WR_NONE, 1'b0, SQ_NEXT,     ST_IDLE);
      ST_V1:   u = mk(A_VEL,  C_KEEP, ACC_RND,  WR_NONE, 1'b0, SQ_NEXT,     ST_IDLE);
      ST_V2:   u = mk(A_CMD,  C_TAU,  ACC_ADD,  WR_NONE, 1'b0, SQ_NEXT,     ST_IDLE);
      ST_V3:   u = mk(A_CMD,  C_TAU,  ACC_NOP,  WR_V,    1'b0, SQ_JUMP,     ST_T0);
      ST_P0:   u = mk(A_CMD,  C_TAU,  ACC_NOP,  WR_NONE, 1'b0, SQ_NEXT,     ST_IDLE);
      ST_P1:   u = mk(A_POS,  C_KEEP, ACC_RND,  WR_NONE, 1'b0, SQ_NEXT,     ST_IDLE);
      ST_P2:   u = mk(A_CMD,  C_TAU,  ACC_ADD,  WR_NONE, 1'b0, SQ_NEXT,     ST_IDLE);
      ST_P3:   u = mk(A_CMD,  C_TAU,  ACC_NOP,  WR_P,    1'b0, SQ_JUMP,     ST_EMIT);
      default: u = mk(A_CMD,  C_TAU,  ACC_NOP,  WR_NONE, 1'b0, SQ_JUMP,     ST_IDLE);
    endcase
    return u;
  endfunction

endpackage

// ===== design/joint_plant_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// joint_plant_step: simulated multi-axis joint plant
// Command and tick words in, one result word per axis out on every tick.
// ---------------------------------------------------------------------------
// Usage:
// The input stream carries two kinds of word, told apart by in_tuser. A
// command word (tuser 0) stores a Q16.16 command for one axis, for the
// quantity chosen by the control_target register; it gives no result. A
// tick word (tuser 1) advances every axis by one time step and sends one
// result word per axis, axis 0 first, with out_tlast set on the final axis.
// The block works on one word at a time: in_tready is high only while the
// sequencer is idle. A tick runs the microcode once per axis through a
// single shared multiplier; the program per axis is longest in effort mode,
// shorter in velocity mode, shorter still in position mode and shortest
// with the unused target code.
// A result register sits on the output: when the receiver stalls, the
// sequencer holds at its emit step until the register frees up, and no
// result is lost. Reset clears all axis state and commands to zero and loads
// the register defaults. Registers are written through the APB port; the
// user must write them only while the block is idle, which the block itself
// does not enforce.
// ---------------------------------------------------------------------------
module joint_plant_step #(
  parameter int NUM_AXES = jps_pkg::NUM_AXES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // [2:0] axis_index, [34:3] command_value, zero pad
  input  logic         in_tuser,   // [0] opcode: 0 command, 1 tick
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [2:0] out_axis, [34:3] position,
                                   // [66:35] velocity, [98:67] effort, zero pad
  output logic         out_tlast,
  // Configuration port.
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  logic [1:0]  target_r;
  logic [23:0] follow_r;
  logic [23:0] damp_r;
  logic [23:0] hj_r;
  logic [23:0] step_r;

  logic          cfg_wr;
  logic [2:0]    cfg_idx;
  logic          in_fire;
  logic          start;
  logic          cmd_wr;
  logic          idle;
  logic          out_free;
  jps_pkg::ctl_t ctl;
  logic [AW-1:0] axis;

  logic [2:0]  res_axis;
  logic [31:0] res_p, res_v, res_e;

  // Register file. Writes complete in the access phase; pready is tied high.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= jps_pkg::TARGET_RST;
      follow_r <= jps_pkg::FOLLOW_RST;
      damp_r   <= jps_pkg::DAMP_RST;
      hj_r     <= jps_pkg::HJ_RST;
      step_r   <= jps_pkg::STEP_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        jps_pkg::REG_TARGET: target_r <= cfg_pwdata[1:0];
        jps_pkg::REG_FOLLOW: follow_r <= cfg_pwdata[23:0];
        jps_pkg::REG_DAMP:   damp_r   <= cfg_pwdata[23:0];
        jps_pkg::REG_HJ:     hj_r     <= cfg_pwdata[23:0];
        jps_pkg::REG_STEP:   step_r   <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      jps_pkg::REG_TARGET: cfg_prdata = {30'd0, target_r};
      jps_pkg::REG_FOLLOW: cfg_prdata = {8'd0, follow_r};
      jps_pkg::REG_DAMP:   cfg_prdata = {8'd0, damp_r};
      jps_pkg::REG_HJ:     cfg_prdata = {8'd0, hj_r};
      jps_pkg::REG_STEP:   cfg_prdata = {8'd0, step_r};
      default:             cfg_prdata = 32'd0;
    endcase
  end

  // A word is taken only while the sequencer sits idle. Commands are stored
  // at once; a tick starts the per-axis program.
  assign in_tready = idle;
  assign in_fire   = in_tvalid && in_tready;
  assign start     = in_fire && in_tuser;
  assign cmd_wr    = in_fire && !in_tuser;

  jps_ucode #(
    .NUM_AXES (NUM_AXES)
  ) u_ucode (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .target   (target_r),
    .out_free (out_free),
    .ctl      (ctl),
    .axis     (axis),
    .idle     (idle)
  );

  jps_datapath #(
    .NUM_AXES (NUM_AXES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .axis              (axis),
    .target            (target_r),
    .follow_gain       (follow_r),
    .damping_gain      (damp_r),
    .step_over_inertia (hj_r),
    .time_step         (step_r),
    .cmd_wr            (cmd_wr),
    .cmd_axis          (in_tdata[2:0]),
    .cmd_value         (in_tdata[34:3]),
    .out_ready         (out_tready),
    .out_free          (out_free),
    .out_valid         (out_tvalid),
    .out_axis          (res_axis),
    .out_position      (res_p),
    .out_velocity      (res_v),
    .out_effort        (res_e),
    .out_last          (out_tlast)
  );

  assign out_tdata = {5'd0, res_e, res_v, res_p, res_axis};

endmodule

// ===== design/jps_ucode.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jps_ucode: microcode sequencer of the joint plant
// Step counter over the control ROM, mode dispatch and the axis counter.
// ---------------------------------------------------------------------------
module jps_ucode #(
  parameter int NUM_AXES = jps_pkg::NUM_AXES_DEF,
  localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          target,
  input  logic                out_free,
  output jps_pkg::ctl_t       ctl,
  output logic [AW-1:0]       axis,
  output logic                idle
);

  jps_pkg::step_t  step_r, step_nxt;
  logic [AW-1:0]   axis_r, axis_nxt;
  jps_pkg::uword_t uw;
  logic            last;
  logic            emit;

  assign uw   = jps_pkg::ucode_rom(step_r);
  assign last = (axis_r == AW'(NUM_AXES - 1));
  assign idle = (step_r == jps_pkg::ST_IDLE);

  always_comb begin
    step_nxt = step_r;
    axis_nxt = axis_r;
    emit     = 1'b0;
    case (uw.seq)
      jps_pkg::SQ_IDLE: begin
        if (start) begin
          step_nxt = jps_pkg::ST_WAIT;
          axis_nxt = '0;
        end
      end
      jps_pkg::SQ_NEXT: begin
        step_nxt = step_r + jps_pkg::step_t'(1);
      end
      jps_pkg::SQ_JUMP: begin
        step_nxt = uw.jaddr;
      end
      jps_pkg::SQ_DISPATCH: begin
        case (target)
          jps_pkg::TGT_EFFORT:   step_nxt = jps_pkg::ST_E0;
          jps_pkg::TGT_VELOCITY: step_nxt = jps_pkg::ST_V0;
          jps_pkg::TGT_POSITION: step_nxt = jps_pkg::ST_P0;
          // Unused code: velocity and effort stay cleared, position holds.
          default:               step_nxt = jps_pkg::ST_T0;
        endcase
      end
      jps_pkg::SQ_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (last) begin
            step_nxt = jps_pkg::ST_IDLE;
          end else begin
            axis_nxt = axis_r + AW'(1);
            step_nxt = jps_pkg::ST_WAIT;
          end
        end
      end
      default: begin
        step_nxt = jps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= jps_pkg::ST_IDLE;
      axis_r <= '0;
    end else begin
      step_r <= step_nxt;
      axis_r <= axis_nxt;
    end
  end

  assign ctl  = {uw, emit, last};
  assign axis = axis_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> idle) else $error("tick started while sequencer busy");

  a_start_axis0: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (step_r == jps_pkg::ST_WAIT) && (axis_r == '0))
    else $error("tick did not begin at axis zero");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last) |=> idle) else $error("sequencer ran past the final axis");

  a_axis_step: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !last) |=> (axis_r == $past(axis_r) + AW'(1)))
    else $error("axis counter skipped");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    !idle |-> (7'(axis_r) < 7'(NUM_AXES))) else $error("axis out of range");
`endif

endmodule

// ===== design/jps_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jps_datapath: multiply-accumulate datapath and state memories
// Shared multiplier, rounding accumulator with saturation, the per-axis
// state and command memories, and the result register.
// ---------------------------------------------------------------------------
module jps_datapath #(
  parameter int NUM_AXES = jps_pkg::NUM_AXES_DEF,
  localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  jps_pkg::ctl_t      ctl,
  input  logic [AW-1:0]      axis,
  input  logic [1:0]         target,
  input  logic [23:0]        follow_gain,
  input  logic [23:0]        damping_gain,
  input  logic [23:0]        step_over_inertia,
  input  logic [23:0]        time_step,
  input  logic               cmd_wr,
  input  logic [2:0]         cmd_axis,
  input  logic [31:0]        cmd_value,
  input  logic               out_ready,
  output logic               out_free,
  output logic               out_valid,
  output logic [2:0]         out_axis,
  output logic [31:0]        out_position,
  output logic [31:0]        out_velocity,
  output logic [31:0]        out_effort,
  output logic               out_last
);

  localparam int ST_DEPTH  = 1 << AW;
  localparam int CAW       = AW + 2;
  localparam int CMD_DEPTH = 1 << CAW;

  // Command memory, addressed by {target, axis}; state memory holds {e, v, p}.
  logic [31:0] cmd_mem [CMD_DEPTH];
  logic [95:0] st_mem  [ST_DEPTH];
  logic [CMD_DEPTH-1:0] cmd_vld_r;
  logic [ST_DEPTH-1:0]  st_vld_r;

  logic [31:0] cmd_rd_r;
  logic [95:0] st_rd_r;
  logic        cmd_rv_r;
  logic        st_rv_r;

  logic [6:0]     cax_w;
  logic [6:0]     axis_w;
  logic [CAW-1:0] cmd_waddr;
  logic [CAW-1:0] cmd_raddr;
  logic           cmd_we;

  logic signed [31:0] cmd_q, p_old, v_old, e_old;
  logic signed [31:0] e_new_r, v_new_r, p_new_r;
  logic signed [31:0] op_a;
  logic        [24:0] coef;
  logic        [24:0] keep;
  logic signed [25:0] coef_s;
  logic signed [57:0] prod_r, prod_nxt;
  logic signed [57:0] rsum;
  logic signed [35:0] rnd;
  logic signed [35:0] acc_r, acc_nxt;
  logic signed [31:0] sat;

  logic        out_valid_r;
  logic [2:0]  out_axis_r;
  logic [31:0] out_p_r, out_v_r, out_e_r;
  logic        out_last_r;

  assign cax_w     = 7'(cmd_axis);
  assign axis_w    = 7'(axis);
  assign cmd_waddr = {target, cax_w[AW-1:0]};
  assign cmd_raddr = {target, axis};
  // Commands for axes beyond the array or for the unused target are dropped.
  assign cmd_we    = cmd_wr && (cax_w < 7'(NUM_AXES)) &&
                     ((target == jps_pkg::TGT_POSITION) ||
                      (target == jps_pkg::TGT_VELOCITY) ||
                      (target == jps_pkg::TGT_EFFORT));

  always_ff @(posedge clk) begin
    if (cmd_we) begin
      cmd_mem[cmd_waddr] <= cmd_value;
    end
    if (ctl.emit) begin
      st_mem[axis] <= {e_new_r, v_new_r, p_new_r};
    end
    cmd_rd_r <= cmd_mem[cmd_raddr];
    st_rd_r  <= st_mem[axis];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= '0;
      st_vld_r  <= '0;
      cmd_rv_r  <= 1'b0;
      st_rv_r   <= 1'b0;
    end else begin
      if (cmd_we) begin
        cmd_vld_r[cmd_waddr] <= 1'b1;
      end
      if (ctl.emit) begin
        st_vld_r[axis] <= 1'b1;
      end
      cmd_rv_r <= cmd_vld_r[cmd_raddr];
      st_rv_r  <= st_vld_r[axis];
    end
  end

  // Entries never written read as zero.
  assign cmd_q = cmd_rv_r ? cmd_rd_r        : '0;
  assign p_old = st_rv_r  ? st_rd_r[31:0]   : '0;
  assign v_old = st_rv_r  ? st_rd_r[63:32]  : '0;
  assign e_old = st_rv_r  ? st_rd_r[95:64]  : '0;

  assign keep = 25'h1000000 - {1'b0, follow_gain};

  always_comb begin
    case (ctl.uw.asel)
      jps_pkg::A_CMD:  op_a = cmd_q;
      jps_pkg::A_POS:  op_a = p_old;
      jps_pkg::A_VEL:  op_a = v_old;
      jps_pkg::A_EFF:  op_a = e_old;
      jps_pkg::A_ENEW: op_a = e_new_r;
      jps_pkg::A_VNEW: op_a = v_new_r;
      default:         op_a = cmd_q;
    endcase
    case (ctl.uw.csel)
      jps_pkg::C_TAU:  coef = {1'b0, follow_gain};
      jps_pkg::C_KEEP: coef = keep;
      jps_pkg::C_DAMP: coef = {1'b0, damping_gain};
      jps_pkg::C_HJ:   coef = {1'b0, step_over_inertia};
      jps_pkg::C_H:    coef = {1'b0, time_step};
      default:         coef = {1'b0, follow_gain};
    endcase
  end

  assign coef_s   = $signed({1'b0, coef});
  assign prod_nxt = op_a * coef_s;

  // Round half up: add one half LSB of the result, then floor shift by 24.
  assign rsum = prod_r + 58'sd8388608;
  assign rnd  = {{2{rsum[57]}}, rsum[57:24]};

  always_comb begin
    case (ctl.uw.acc)
      jps_pkg::ACC_NOP:  acc_nxt = acc_r;
      jps_pkg::ACC_RND:  acc_nxt = rnd;
      jps_pkg::ACC_ADD:  acc_nxt = acc_r + rnd;
      jps_pkg::ACC_SUB:  acc_nxt = acc_r - rnd;
      jps_pkg::ACC_VOLD: acc_nxt = {{4{v_old[31]}}, v_old} + rnd;
      jps_pkg::ACC_POLD: acc_nxt = {{4{p_old[31]}}, p_old} + rnd;
      default:           acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    if (!acc_r[35] && (acc_r[34:31] != 4'b0000)) begin
      sat = 32'sh7FFFFFFF;
    end else if (acc_r[35] && (acc_r[34:31] != 4'b1111)) begin
      sat = 32'sh80000000;
    end else begin
      sat = acc_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (ctl.uw.clr) begin
      e_new_r <= '0;
      v_new_r <= '0;
    end
    case (ctl.uw.wr)
      jps_pkg::WR_E: e_new_r <= sat;
      jps_pkg::WR_V: v_new_r <= sat;
      jps_pkg::WR_P: p_new_r <= sat;
      default: ;
    endcase
  end

  // Result register: frees the sequencer while a result waits downstream.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_axis_r <= axis_w[2:0];
      out_p_r    <= p_new_r;
      out_v_r    <= v_new_r;
      out_e_r    <= e_new_r;
      out_last_r <= ctl.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_axis     = out_axis_r;
  assign out_position = out_p_r;
  assign out_velocity = out_v_r;
  assign out_effort   = out_e_r;
  assign out_last     = out_last_r;

endmodule

// ===== bench/joint_plant_step_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// joint_plant_step_checker: result predictor and scoreboard for the plant
// Watches the configuration port and both streams, keeps its own copy of the
// axis state and registers, and compares every result word in order.
// ---------------------------------------------------------------------------
package jps_bench_pkg;

  // Word kind carried on in_tuser.
  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // The one control_target code that selects no quantity.
  localparam logic [1:0] TGT_UNUSED = 2'd3;

endpackage

module joint_plant_step_checker #(
  parameter int NUM_AXES = jps_pkg::NUM_AXES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [39:0]  in_tdata,   // [2:0] axis_index, [34:3] command_value, zero pad
  input  logic         in_tuser,   // [0] opcode
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,  // [2:0] out_axis, [34:3] position,
                                   // [66:35] velocity, [98:67] effort, zero pad
  input  logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           mismatches,
  output int           pending,
  output int           checked
);

  typedef struct {
    logic [2:0]         axis;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] eff;
    logic               last;
  } axis_sample_t;

  axis_sample_t expected_samples[$];

  logic signed [31:0] plant_pos[NUM_AXES];
  logic signed [31:0] plant_vel[NUM_AXES];
  logic signed [31:0] plant_eff[NUM_AXES];
  logic signed [31:0] pos_cmd[NUM_AXES];
  logic signed [31:0] vel_cmd[NUM_AXES];
  logic signed [31:0] eff_cmd[NUM_AXES];

  logic [1:0]  target;
  logic [23:0] tau;
  logic [23:0] damp;
  logic [23:0] h_over_j;
  logic [23:0] h_step;

  // Q16.16 times Q1.24, plus half an LSB, floored back to Q16.16.
  function automatic longint scale_q24(input logic signed [31:0] x, input logic [24:0] c);
    longint prod;
    prod = longint'(x) * longint'({39'd0, c}) + 64'sd8388608;
    return prod >>> 24;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // One simulation tick: every axis advances and queues its result word.
  task automatic advance_plant();
    logic [24:0]        keep;
    logic signed [31:0] p_new;
    logic signed [31:0] v_new;
    logic signed [31:0] e_new;
    axis_sample_t       s;
    keep = 25'd16777216 - {1'b0, tau};
    for (int i = 0; i < NUM_AXES; i++) begin
      v_new = '0;
      e_new = '0;
      if (target == jps_pkg::TGT_EFFORT) begin
        e_new = clamp32(scale_q24(eff_cmd[i], {1'b0, tau}) + scale_q24(plant_eff[i], keep)
                        - scale_q24(plant_vel[i], {1'b0, damp}));
        v_new = clamp32(longint'(plant_vel[i]) + scale_q24(e_new, {1'b0, h_over_j}));
      end else if (target == jps_pkg::TGT_VELOCITY) begin
        v_new = clamp32(scale_q24(vel_cmd[i], {1'b0, tau}) + scale_q24(plant_vel[i], keep));
      end
      // Position integrates the new velocity, except in position mode where it
      // follows its own command; with the unused code velocity is zero, so it holds.
      if (target == jps_pkg::TGT_POSITION)
        p_new = clamp32(scale_q24(pos_cmd[i], {1'b0, tau}) + scale_q24(plant_pos[i], keep));
      else
        p_new = clamp32(longint'(plant_pos[i]) + scale_q24(v_new, {1'b0, h_step}));
      plant_pos[i] = p_new;
      plant_vel[i] = v_new;
      plant_eff[i] = e_new;
      s.axis = i[2:0];
      s.pos  = p_new;
      s.vel  = v_new;
      s.eff  = e_new;
      s.last = (i == NUM_AXES - 1);
      expected_samples.insert(expected_samples.size(), s);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : monitor
    axis_sample_t want;
    logic [2:0]   cmd_axis;
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        plant_pos[i] = '0;
        plant_vel[i] = '0;
        plant_eff[i] = '0;
        pos_cmd[i]   = '0;
        vel_cmd[i]   = '0;
        eff_cmd[i]   = '0;
      end
      target   = jps_pkg::TARGET_RST;
      tau      = jps_pkg::FOLLOW_RST;
      damp     = jps_pkg::DAMP_RST;
      h_over_j = jps_pkg::HJ_RST;
      h_step   = jps_pkg::STEP_RST;
      expected_samples.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          jps_pkg::REG_TARGET: target   = cfg_pwdata[1:0];
          jps_pkg::REG_FOLLOW: tau      = cfg_pwdata[23:0];
          jps_pkg::REG_DAMP:   damp     = cfg_pwdata[23:0];
          jps_pkg::REG_HJ:     h_over_j = cfg_pwdata[23:0];
          jps_pkg::REG_STEP:   h_step   = cfg_pwdata[23:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == jps_bench_pkg::OP_TICK) begin
          advance_plant();
        end else begin
          cmd_axis = in_tdata[2:0];
          if (cmd_axis < NUM_AXES) begin
            case (target)
              jps_pkg::TGT_POSITION: pos_cmd[cmd_axis] = in_tdata[34:3];
              jps_pkg::TGT_VELOCITY: vel_cmd[cmd_axis] = in_tdata[34:3];
              jps_pkg::TGT_EFFORT:   eff_cmd[cmd_axis] = in_tdata[34:3];
              default: ;
            endcase
          end
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("result word with nothing expected, axis",
                          {29'd0, out_tdata[2:0]}, 32'd0);
        end else begin
          want = expected_samples.pop_front();
          checked++;
          if (out_tdata[2:0] !== want.axis)
            report_mismatch("axis", {29'd0, out_tdata[2:0]}, {29'd0, want.axis});
          if (out_tdata[34:3] !== want.pos)
            report_mismatch($sformatf("position of axis %0d", want.axis),
                            out_tdata[34:3], want.pos);
          if (out_tdata[66:35] !== want.vel)
            report_mismatch($sformatf("velocity of axis %0d", want.axis),
                            out_tdata[66:35], want.vel);
          if (out_tdata[98:67] !== want.eff)
            report_mismatch($sformatf("effort of axis %0d", want.axis),
                            out_tdata[98:67], want.eff);
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last marker of axis %0d", want.axis),
                            {31'd0, out_tlast}, {31'd0, want.last});
        end
      end
    end
    pending = expected_samples.size();
  end

endmodule

// ===== bench/joint_plant_step_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// joint_plant_step_tb: testbench top for the joint plant
// Drives command and tick words and register writes, stalls the result side,
// and gives the verdict from the checker's mismatch and pending counts.
// ---------------------------------------------------------------------------
module joint_plant_step_tb;

  localparam int NUM_AXES = jps_pkg::NUM_AXES_DEF;

  // The receiver is held off once for the HOLD_CYCLES hold-off; the
  // quiet-cycle limit sits far above that and above an effort-mode tick.
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  // Cycles let pass after the last expected result before the block counts
  // as idle; covers the tail of a tick once its final word has gone out.
  localparam int SETTLE_CYCLES = 40;
  localparam int SEGMENT_WORDS = 44;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [39:0]  in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic         out_tlast;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  int mismatches;
  int expected_left;
  int checked;

  // Idle rates in percent for the sender and the receiver, changed per phase.
  int send_idle_pct = 7;
  int recv_idle_pct = 73;
  bit hold_armed    = 1'b0;

  int n_ticks;
  int n_commands;
  int n_settings;
  int quiet_cycles;

  always #5 clk = ~clk;

  joint_plant_step #(
    .NUM_AXES(NUM_AXES)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  joint_plant_step_checker #(
    .NUM_AXES(NUM_AXES)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_pready (cfg_pready),
    .mismatches (mismatches),
    .pending    (expected_left),
    .checked    (checked)
  );

  // Receiver: ready changes at the falling edge. Once the stimulus arms the
  // hold-off, ready stays low until the HOLD_CYCLES count kept here runs out,
  // so the result register fills, the sequencer parks at its emit step and
  // the input side stalls while the sender keeps offering words.
  initial begin : receiver
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any handshake on any port counts as progress.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d results still expected",
               STALL_LIMIT, expected_left);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one word and returns at the edge where it is taken. Valid stays
  // high into the next call, so back-to-back words without idling keep it asserted.
  task automatic send_word(input logic op, input logic [2:0] axis, input logic [31:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {5'd0, value, axis};
    do @(posedge clk); while (!in_tready);
    if (op == jps_bench_pkg::OP_TICK) n_ticks++;
    else n_commands++;
  endtask

  // APB write: setup cycle, then access cycle. Half the writes carry random
  // bits above the register's width, which the block has to drop.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] junk;
    junk = (idx == jps_pkg::REG_TARGET) ? 32'hFFFF_FFFC : 32'hFF00_0000;
    if ($urandom_range(1)) value = value | ($urandom() & junk);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Stops offering words and waits until every predicted result has arrived,
  // then lets the tail of the last tick run out.
  task automatic wait_for_drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [23:0] pick_gain();
    case ($urandom_range(5))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      2: return 24'($urandom_range(24'hFF_FFFF));
      default: return 24'($urandom_range(1, 2000000));  // the range a real plant uses
    endcase
  endfunction

  function automatic logic [31:0] pick_command();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom_range(32'h0010_0000) - 32'h0008_0000;  // within +-8.0
      default: return $urandom();
    endcase
  endfunction

  // A new register setting: the target every time, the gains now and then,
  // and once in a while a write to an address past the last register.
  task automatic random_settings();
    logic [1:0] tgt;
    case ($urandom_range(9))
      0, 1, 2: tgt = jps_pkg::TGT_EFFORT;
      3, 4, 5: tgt = jps_pkg::TGT_VELOCITY;
      6, 7, 8: tgt = jps_pkg::TGT_POSITION;
      default: tgt = jps_bench_pkg::TGT_UNUSED;
    endcase
    write_reg(jps_pkg::REG_TARGET, {30'd0, tgt});
    if ($urandom_range(9) < 7) write_reg(jps_pkg::REG_FOLLOW, {8'd0, pick_gain()});
    if ($urandom_range(9) < 7) write_reg(jps_pkg::REG_DAMP, {8'd0, pick_gain()});
    if ($urandom_range(9) < 7) write_reg(jps_pkg::REG_HJ, {8'd0, pick_gain()});
    if ($urandom_range(9) < 7) write_reg(jps_pkg::REG_STEP, {8'd0, pick_gain()});
    if ($urandom_range(7) == 0)
      write_reg(3'($urandom_range(int'(jps_pkg::REG_STEP) + 1, 7)), $urandom());
    n_settings++;
  endtask

  // Random words: half ticks, half commands to random axes. A tick carries
  // random axis and value bits, which the block must ignore.
  task automatic run_segment(input int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(1))
        send_word(jps_bench_pkg::OP_TICK, 3'($urandom_range(7)), $urandom());
      else
        send_word(jps_bench_pkg::OP_COMMAND, 3'($urandom_range(7)), pick_command());
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = jps_bench_pkg::OP_COMMAND;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, register defaults first. A tick on the all-zero plant,
    // then effort commands at both ends of the range and one small one.
    send_word(jps_bench_pkg::OP_TICK, 3'd0, 32'd0);
    send_word(jps_bench_pkg::OP_COMMAND, 3'd0, 32'h7FFF_FFFF);
    send_word(jps_bench_pkg::OP_COMMAND, 3'd7, 32'h8000_0000);
    send_word(jps_bench_pkg::OP_COMMAND, 3'd3, 32'h0001_0000);
    send_word(jps_bench_pkg::OP_TICK, 3'd5, 32'hFFFF_FFFF);
    send_word(jps_bench_pkg::OP_TICK, 3'd2, 32'h5555_AAAA);
    wait_for_drain();

    // Largest gains with no damping push sums into saturation.
    write_reg(jps_pkg::REG_FOLLOW, 32'h00FF_FFFF);
    write_reg(jps_pkg::REG_DAMP, 32'd0);
    write_reg(jps_pkg::REG_HJ, 32'h00FF_FFFF);
    write_reg(jps_pkg::REG_STEP, 32'h00FF_FFFF);
    send_word(jps_bench_pkg::OP_TICK, 3'd0, 32'd0);
    send_word(jps_bench_pkg::OP_TICK, 3'd7, 32'd0);
    wait_for_drain();

    // Velocity mode keeps the effort commands from before but zeroes the effort state.
    write_reg(jps_pkg::REG_TARGET, {30'd0, jps_pkg::TGT_VELOCITY});
    send_word(jps_bench_pkg::OP_COMMAND, 3'd1, 32'h8000_0000);
    send_word(jps_bench_pkg::OP_COMMAND, 3'd5, 32'h7FFF_FFFF);
    send_word(jps_bench_pkg::OP_TICK, 3'd0, 32'd0);
    wait_for_drain();

    write_reg(jps_pkg::REG_TARGET, {30'd0, jps_pkg::TGT_POSITION});
    send_word(jps_bench_pkg::OP_COMMAND, 3'd2, 32'h7FFF_FFFF);
    send_word(jps_bench_pkg::OP_COMMAND, 3'd6, 32'h8000_0000);
    send_word(jps_bench_pkg::OP_TICK, 3'd0, 32'd0);
    wait_for_drain();

    // The unused target code: the command is dropped, and the tick zeroes
    // effort and velocity while position holds.
    write_reg(jps_pkg::REG_TARGET, {30'd0, jps_bench_pkg::TGT_UNUSED});
    send_word(jps_bench_pkg::OP_COMMAND, 3'd4, 32'h1234_5678);
    send_word(jps_bench_pkg::OP_TICK, 3'd0, 32'd0);
    wait_for_drain();

    // Writes past the last register must change nothing.
    for (int idx = int'(jps_pkg::REG_STEP) + 1; idx < 8; idx++)
      write_reg(3'(idx), $urandom());
    send_word(jps_bench_pkg::OP_TICK, 3'd0, 32'd0);
    wait_for_drain();

    // No following at all (the keep factor is exactly one) with full damping.
    write_reg(jps_pkg::REG_TARGET, {30'd0, jps_pkg::TGT_EFFORT});
    write_reg(jps_pkg::REG_FOLLOW, 32'd0);
    write_reg(jps_pkg::REG_DAMP, 32'h00FF_FFFF);
    write_reg(jps_pkg::REG_HJ, 32'd0);
    write_reg(jps_pkg::REG_STEP, 32'd0);
    send_word(jps_bench_pkg::OP_TICK, 3'd0, 32'd0);
    n_settings = 6;

    // Random part in three idle phases: sender rarely idle and receiver
    // mostly stalled, then the reverse, then both at full rate. Each phase
    // runs several register settings, changed only once the plant is drained.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        wait_for_drain();
        random_settings();
        // In the full-rate phase the receiver is held off once while the
        // sender keeps going, so the block backs up into its input.
        if (phase == 2 && seg == 1) hold_armed = 1'b1;
        run_segment(SEGMENT_WORDS);
      end
    end

    wait_for_drain();
    $display("Covered %0d command words and %0d ticks over %0d register settings,",
             n_commands, n_ticks, n_settings);
    $display("all target codes included; %0d result words checked, %0d mismatches.",
             checked, mismatches);
    if (mismatches == 0 && expected_left == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
